### rtl/precision_quantizer_assert.svh
// assertion macros for the precision quantizer checker
`ifndef PRECISION_QUANTIZER_ASSERT_SVH
`define PRECISION_QUANTIZER_ASSERT_SVH
// implication checked on every clock unless reset
`define PQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define PQ_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

### rtl/pq_pkg.sv
// shared types and constants of the precision quantizer
`default_nettype none
package pq_pkg;
   typedef enum logic [2:0] {
      FMT_F64  = 3'd0,
      FMT_F32  = 3'd1,
      FMT_F16  = 3'd2,
      FMT_BF16 = 3'd3,
      FMT_I8   = 3'd4,
      FMT_R5   = 3'd5,
      FMT_R6   = 3'd6,
      FMT_R7   = 3'd7
   } fmt_type;
   localparam int LATENCY = 4;
   localparam logic [63:0] MASK52 = 64'h000F_FFFF_FFFF_FFFF;
   localparam logic [63:0] POS127 = 64'h405F_C000_0000_0000;
   localparam logic [63:0] NEG128 = 64'hC060_0000_0000_0000;
   localparam logic [63:0] MAG128 = 64'h4060_0000_0000_0000;
   localparam logic [63:0] INF64  = 64'h7FF0_0000_0000_0000;
endpackage
`default_nettype wire

### rtl/precision_quantizer.sv
// precision quantizer: pipelined double to storage format and back
// usage:
//   write csr_data with csr_valid (csr_ready is always high) to choose the
//   format: 0 f64, 1 f32, 2 f16, 3 bf16, 4 int8, others as f64.
//   an item is taken when req_start is high and req_busy low; busy never
//   rises, so one item enters every clock cycle.
//   each result shows on rsp_result_bits for one cycle with rsp_strobe,
//   in order, once the item has passed the four register stages.
//   the pipeline has four register stages: decode, round to single or
//   integer, half round and renormalize, widen to double.
//   the receiver cannot stall; results are never held.
//   reset clears the valid bits and sets the format to f64.
`default_nettype none
module precision_quantizer (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_start,
   output logic        req_busy,
   input  wire  [63:0] req_value_bits,
   output logic        rsp_strobe,
   output logic [63:0] rsp_result_bits,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [2:0]  csr_data
);
   import pq_pkg::*;

   // leading one position of a 53 bit word, 0 if none
   function automatic logic [5:0] msb53(input logic [52:0] v);
      logic [5:0] p;
      p = 6'd0;
      for (int i = 0; i < 53; i++) if (v[i]) p = 6'(i);
      return p;
   endfunction

   // leading one of a 23 bit word
   function automatic logic [4:0] msb23(input logic [22:0] v);
      logic [4:0] p;
      p = 5'd0;
      for (int i = 0; i < 23; i++) if (v[i]) p = 5'(i);
      return p;
   endfunction

   fmt_type fmt_ff;
   assign csr_ready = 1'b1;
   assign req_busy  = 1'b0;

   // format register
   always_ff @(posedge clock) begin
      if (reset) fmt_ff <= FMT_F64;
      else if (csr_valid) fmt_ff <= fmt_type'(csr_data);
   end

   // stage 1: capture item and format
   logic        v1_ff;
   logic [63:0] b1_ff;
   fmt_type     f1_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= req_start;
      b1_ff <= req_value_bits;
      f1_ff <= fmt_ff;
   end

   // stage 2 logic: round double to single, and int8 rounding
   logic [31:0] sgl_in;
   logic [63:0] i8_in;
   logic        i8_done_in;
   logic [52:0] i8q_in;
   always_comb begin
      logic        s;
      logic [10:0] e;
      logic [51:0] m;
      logic signed [12:0] fe;
      logic [6:0]  sh;
      logic [52:0] sig, q, rem, half, mk;
      logic [63:0] r, mag;
      s = b1_ff[63];
      e = b1_ff[62:52];
      m = b1_ff[51:0];
      fe = $signed({2'b0, e}) - 13'sd896;
      sgl_in = {s, 31'd0};
      sh = 7'd29;
      if (fe < 13'sd1) sh = 7'(13'sd30 - fe);
      sig = {1'b1, m};
      if (sh > 7'd53) sh = 7'd63;
      q = (sh >= 7'd53) ? 53'd0 : (sig >> sh);
      mk = (sh >= 7'd53) ? {53{1'b1}} : ((53'd1 << sh) - 53'd1);
      rem = sig & mk;
      half = (sh > 7'd53) ? 53'd0 : (53'd1 << (sh - 7'd1));
      if (sh <= 7'd53 && (rem > half || (rem == half && q[0]))) q = q + 53'd1;
      r = (fe >= 13'sd1) ? ((64'(fe - 13'sd1) << 23) + 64'(q)) : 64'(q);
      if (e == 11'h7FF) begin
         sgl_in = (m == 52'd0) ? {s, 31'h7F80_0000}
                               : {s, 8'hFF, 1'b1, m[50:29]};
      end else if (e == 11'd0) begin
         sgl_in = {s, 31'd0};
      end else if (fe >= 13'sd255) begin
         sgl_in = {s, 31'h7F80_0000};
      end else if (fe < 13'sd1 && (13'sd1 - fe) > 13'sd34) begin
         sgl_in = {s, 31'd0};
      end else if (r >= 64'h7F80_0000) begin
         sgl_in = {s, 31'h7F80_0000};
      end else begin
         sgl_in = {s, r[30:0]};
      end
      // int8 path
      mag = {1'b0, b1_ff[62:0]};
      i8_in = {s, 63'd0};
      i8_done_in = 1'b1;
      i8q_in = 53'd0;
      if (mag > INF64) i8_in = b1_ff | 64'h0008_0000_0000_0000;
      else if (!s && mag > POS127) i8_in = POS127;
      else if (s && mag > MAG128) i8_in = NEG128;
      else if (e >= 11'd1075) i8_in = b1_ff;
      else if (e < 11'd1022) i8_in = {s, 63'd0};
      else begin
         i8_done_in = 1'b0;
         sh = 7'(11'd1075 - e);
         q = sig >> sh;
         mk = (53'd1 << sh) - 53'd1;
         rem = sig & mk;
         half = 53'd1 << (sh - 7'd1);
         if (rem > half || (rem == half && q[0])) q = q + 53'd1;
         i8q_in = q;
      end
   end

   logic        v2_ff, i8d2_ff;
   logic [31:0] sgl2_ff;
   logic [63:0] i82_ff;
   logic [52:0] i8q2_ff;
   fmt_type     f2_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else v2_ff <= v1_ff;
      sgl2_ff <= sgl_in;
      i82_ff  <= (f1_ff == FMT_I8) ? i8_in : b1_ff;
      i8d2_ff <= i8_done_in || (f1_ff != FMT_I8);
      i8q2_ff <= i8q_in;
      f2_ff   <= f1_ff;
   end

   // stage 3 logic: half round trip, bf16 mask, int8 renormalize
   logic [31:0] s3_in;
   logic [63:0] d3_in;
   always_comb begin
      logic [15:0] h;
      logic [7:0]  ef;
      logic signed [9:0] ex;
      logic [23:0] mm;
      logic [22:0] m;
      logic [4:0]  he, p5;
      logic [9:0]  hm, hmn;
      logic [5:0]  p;
      logic        s;
      s = sgl2_ff[31];
      ef = sgl2_ff[30:23];
      m = sgl2_ff[22:0];
      mm = 24'd0;
      ex = $signed({2'b0, ef}) - 10'sd112;
      if (ex <= 10'sd0) begin
         if (ex < -10'sd10) h = {s, 15'd0};
         else begin
            mm = {1'b1, m} >> (10'sd1 - ex);
            h = {s, 15'(({8'd0, mm} + 32'h1000) >> 13)};
         end
      end else if (ex >= 10'sd31) begin
         h = (ef == 8'hFF && m != 23'd0) ? {s, 15'h7E00} : {s, 15'h7C00};
      end else begin
         h = {s, 15'((32'(ex) << 10) + ((32'(m) + 32'h1000) >> 13))};
      end
      // half back to single
      he = h[14:10];
      hm = h[9:0];
      p5 = msb23({13'd0, hm});
      hmn = 10'(hm << (5'd10 - p5));
      if (he == 5'd0) begin
         s3_in = (hm == 10'd0) ? {h[15], 31'd0}
               : {h[15], 8'(8'd103 + {3'd0, p5}), hmn, 13'd0};
      end else if (he == 5'd31) s3_in = {h[15], 8'hFF, hm, 13'd0};
      else s3_in = {h[15], 8'({3'd0, he} + 8'd112), hm, 13'd0};
      case (f2_ff)
         FMT_F16:  ;
         FMT_BF16: s3_in = {sgl2_ff[31:16], 16'd0};
         default:  s3_in = sgl2_ff;
      endcase
      // int8 renormalize
      p = msb53(i8q2_ff);
      if (i8d2_ff) d3_in = i82_ff;
      else if (i8q2_ff == 53'd0) d3_in = {i82_ff[63], 63'd0};
      else d3_in = {i82_ff[63], 11'(11'd1023 + {5'd0, p}),
                    52'(({11'd0, i8q2_ff} << (6'd52 - p)) & MASK52)};
   end

   logic        v3_ff;
   logic [31:0] s3_ff;
   logic [63:0] d3_ff;
   fmt_type     f3_ff;
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else v3_ff <= v2_ff;
      s3_ff <= s3_in;
      d3_ff <= d3_in;
      f3_ff <= f2_ff;
   end

   // stage 4 logic: single widened to double
   logic [63:0] w4_in, out_in;
   always_comb begin
      logic [7:0]  e;
      logic [22:0] m;
      logic [4:0]  p;
      e = s3_ff[30:23];
      m = s3_ff[22:0];
      p = msb23(m);
      if (e == 8'hFF)
         w4_in = (m == 23'd0) ? {s3_ff[31], 63'h7FF0_0000_0000_0000}
               : {s3_ff[31], 11'h7FF, 52'({29'd0, m} << 29) | 52'h8_0000_0000_0000};
      else if (e == 8'd0)
         w4_in = (m == 23'd0) ? {s3_ff[31], 63'd0}
               : {s3_ff[31], 11'(11'd874 + {6'd0, p}),
                  52'(({29'd0, m} << (6'd52 - {1'b0, p})) & MASK52)};
      else w4_in = {s3_ff[31], 11'({3'd0, e} + 11'd896), m, 29'd0};
      case (f3_ff)
         FMT_F32, FMT_F16, FMT_BF16: out_in = w4_in;
         default: out_in = d3_ff;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) rsp_strobe <= 1'b0;
      else rsp_strobe <= v3_ff;
      rsp_result_bits <= out_in;
   end
endmodule
`default_nettype wire

### rtl/pq_checker.sv
// port checker for the precision quantizer, bound to the top level
`default_nettype none
`include "precision_quantizer_assert.svh"
module pq_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_start,
   input wire        req_busy,
   input wire        rsp_strobe,
   input wire        csr_ready
);
   // strobe follows an accepted item after the pipeline depth
   `PQ_ASSERT_IMP(a_lat, clock, reset, $past(req_start && !req_busy, 4) && !$past(reset, 4) && !$past(reset, 3) && !$past(reset, 2) && !$past(reset, 1), rsp_strobe)
   // no strobe without an accepted item the pipeline depth earlier
   `PQ_ASSERT_IMP(a_nogen, clock, reset, rsp_strobe, $past(req_start && !req_busy, 4))
   // block never pushes back
   `PQ_ASSERT_IMP(a_nobusy, clock, reset, 1'b1, !req_busy && csr_ready)
endmodule
bind precision_quantizer pq_checker u_pq_checker (.*);
`default_nettype wire
